// ===== hdl/tpsc_pkg.sv =====
// Shared constants and the sine table generator for the three-phase sine commutator.
`default_nettype none

package tpsc_pkg;

	localparam int TABLE_SIZE = 3000;
	localparam int FRAC_BITS  = 16;

	localparam int IDX_W    = $clog2(TABLE_SIZE);
	localparam int PHASE_W  = IDX_W + FRAC_BITS;
	localparam int STEP_W   = 29;
	localparam int SUM_W    = 30;
	localparam int AMP_W    = 18;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = SAMPLE_W + AMP_W + 1;
	localparam int DUTY_W   = 8;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = 3;

	localparam int CYCLE = TABLE_SIZE << FRAC_BITS;
	localparam int OFS_B = TABLE_SIZE / 3;
	localparam int OFS_C = TABLE_SIZE * 2 / 3;

	localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(19661);

	// Register index decoded from the word address
	localparam logic REG_AMPLITUDE = 1'b0;

	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] K1 = 64'd1686629713;
	localparam logic [63:0] K3 = 64'd693598671;
	localparam logic [63:0] K5 = 64'd85569306;
	localparam logic [63:0] K7 = 64'd5026995;
	localparam logic [63:0] K9 = 64'd172272;

	function automatic logic signed [SAMPLE_W-1:0] rom_sample(input int unsigned i);
		logic [63:0] u;
		logic [1:0]  quad;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] q15;
		u = (64'(i) << 32) / 64'(TABLE_SIZE);
		quad = u[31:30];
		t = u & (Q30_ONE - 64'd1);
		if (quad[0]) begin
			t = Q30_ONE - t;
		end
		t2 = (t * t) >> 30;
		r = K9;
		r = K7 - ((t2 * r) >> 30);
		r = K5 - ((t2 * r) >> 30);
		r = K3 - ((t2 * r) >> 30);
		r = K1 - ((t2 * r) >> 30);
		s = (t * r) >> 30;
		q15 = (s * 64'd32767 + 64'd536870912) >> 30;
		if (q15 > 64'd32767) begin
			q15 = 64'd32767;
		end
		if (quad[1]) begin
			return SAMPLE_W'(-$signed(q15[SAMPLE_W-1:0]));
		end
		return $signed(q15[SAMPLE_W-1:0]);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/tpsc_sine_rom.sv =====
// Sine sample ROM with one registered read port.
`default_nettype none

module tpsc_sine_rom (
	input  wire logic                                  clk,
	input  wire logic                                  en,
	input  wire logic [tpsc_pkg::IDX_W-1:0]            addr,
	output logic signed [tpsc_pkg::SAMPLE_W-1:0]       rdata
);
	import tpsc_pkg::*;

	logic signed [SAMPLE_W-1:0] rom [TABLE_SIZE];
	logic signed [SAMPLE_W-1:0] data_q;

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_rom
		assign rom[i] = rom_sample(i);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= rom[addr];
		end
	end

	assign rdata = data_q;

endmodule

`default_nettype wire

// ===== hdl/three_phase_sine_commutator.sv =====
// Top level of the three-phase sine commutator: phase accumulator, ROM lookup, duty scaling.
`default_nettype none

// Each request (one per PWM period) adds its signed speed_step to a phase accumulator that
// wraps exactly into one table cycle of 3000 entries with 16 fraction bits, even for steps
// larger than a cycle. The integer phase reads the sine ROM at offsets 0, 1000 and 2000
// entries; each sample is scaled by the amplitude register (unsigned Q.16), offset by one,
// multiplied by 127 and clamped to 0..255. fault_led is sticky and includes the current
// request. One request is accepted every cycle unless out_stall backs up the pipeline; after
// acceptance a result passes the phase register (loaded at the accepting edge), then the
// registered ROM read, the multiplier register and the duty register. The ROM holds fixed
// contents and needs no start-up pass. Write amplitude only while no request is in flight.
module three_phase_sine_commutator (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [tpsc_pkg::ADDR_W-1:0]           paddr,
	input  wire logic [tpsc_pkg::DATA_W-1:0]           pwdata,
	output logic      [tpsc_pkg::DATA_W-1:0]           prdata,
	output logic                                       pready,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [tpsc_pkg::STEP_W-1:0]    speed_step,
	input  wire logic                                  fault_n,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic      [tpsc_pkg::DUTY_W-1:0]           pwm_a,
	output logic      [tpsc_pkg::DUTY_W-1:0]           pwm_b,
	output logic      [tpsc_pkg::DUTY_W-1:0]           pwm_c,
	output logic                                       fault_led
);
	import tpsc_pkg::*;

	localparam logic signed [SUM_W-1:0] CYC1 = SUM_W'(CYCLE);
	localparam logic signed [SUM_W-1:0] CYC2 = SUM_W'(2 * CYCLE);
	localparam logic [IDX_W:0] TBL  = (IDX_W+1)'(TABLE_SIZE);

	function automatic logic [DUTY_W-1:0] duty_of(input logic signed [PROD_W-1:0] prod);
		logic signed [PROD_W:0] x;
		logic [PROD_W+7:0]      xe;
		logic [PROD_W+7:0]      n;
		logic [PROD_W+7-31:0]   d;
		x = {prod[PROD_W-1], prod} + (PROD_W+1)'(64'd2147483648);
		xe = (PROD_W+8)'(x[PROD_W-1:0]);
		n = (xe << 7) - xe;
		d = n[PROD_W+7:31];
		if (x[PROD_W]) begin
			return '0;
		end
		if (d > (PROD_W+8-31)'(255)) begin
			return '1;
		end
		return d[DUTY_W-1:0];
	endfunction

	logic [AMP_W-1:0]   amp_q;
	logic [PHASE_W-1:0] phase_q;
	logic               fault_q;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic [IDX_W-1:0]   idx_s1;
	logic               fault_s1, fault_s2, fault_s3, fault_s4;
	logic signed [SAMPLE_W-1:0] sample_s2 [3];
	logic signed [PROD_W-1:0]   prod_s3 [3];
	logic [DUTY_W-1:0]  duty_s4 [3];

	logic ready1, ready2, ready3, ready4;
	logic adv1, accept;
	logic cfg_write;

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] wrapped;
	logic [PHASE_W-1:0]      phase_next;
	logic                    fault_next;
	logic [IDX_W:0]          sum_b, sum_c;
	logic [IDX_W-1:0]        addr [3];
	logic signed [AMP_W:0]   amp_sx;

	// Handshake chain, drains from the output side
	assign ready4   = !valid_s4 || !out_stall;
	assign ready3   = !valid_s3 || ready4;
	assign ready2   = !valid_s2 || ready3;
	assign ready1   = !valid_s1 || ready2;
	assign adv1     = valid_s1 && ready2;
	assign accept   = in_valid && ready1;
	assign in_stall = !ready1;

	assign cfg_write = psel && penable && pwrite && pready;
	assign pready    = 1'b1;

	always_comb begin
		if (paddr[2] == REG_AMPLITUDE) begin
			prdata = DATA_W'(amp_q);
		end else begin
			prdata = '0;
		end
	end

	// Advance the phase and fold it back into one cycle
	always_comb begin
		sum = $signed({2'b00, phase_q}) + SUM_W'(speed_step);
		priority if (sum < -CYC1) begin
			wrapped = sum + CYC2;
		end else if (sum < 0) begin
			wrapped = sum + CYC1;
		end else if (sum >= CYC2) begin
			wrapped = sum - CYC2;
		end else if (sum >= CYC1) begin
			wrapped = sum - CYC1;
		end else begin
			wrapped = sum;
		end
		phase_next = wrapped[PHASE_W-1:0];
		fault_next = fault_q || !fault_n;
	end

	always_comb begin
		sum_b = {1'b0, idx_s1} + (IDX_W+1)'(OFS_B);
		sum_c = {1'b0, idx_s1} + (IDX_W+1)'(OFS_C);
		addr[0] = idx_s1;
		addr[1] = (sum_b >= TBL) ? IDX_W'(sum_b - TBL) : sum_b[IDX_W-1:0];
		addr[2] = (sum_c >= TBL) ? IDX_W'(sum_c - TBL) : sum_c[IDX_W-1:0];
	end

	for (genvar k = 0; k < 3; k++) begin : g_lane
		tpsc_sine_rom u_rom (
			.clk   (clk),
			.en    (adv1),
			.addr  (addr[k]),
			.rdata (sample_s2[k])
		);
	end

	assign amp_sx = $signed({1'b0, amp_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q    <= AMP_RESET;
			phase_q  <= '0;
			fault_q  <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == REG_AMPLITUDE) begin
				amp_q <= pwdata[AMP_W-1:0];
			end
			if (accept) begin
				phase_q <= phase_next;
				fault_q <= fault_next;
			end
			if (ready1) begin
				valid_s1 <= in_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
			if (ready4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= phase_next[PHASE_W-1:FRAC_BITS];
			fault_s1 <= fault_next;
		end
		if (adv1) begin
			fault_s2 <= fault_s1;
		end
		if (valid_s2 && ready3) begin
			fault_s3 <= fault_s2;
			for (int k = 0; k < 3; k++) begin
				prod_s3[k] <= sample_s2[k] * amp_sx;
			end
		end
		if (valid_s3 && ready4) begin
			fault_s4 <= fault_s3;
			for (int k = 0; k < 3; k++) begin
				duty_s4[k] <= duty_of(prod_s3[k]);
			end
		end
	end

	assign out_valid = valid_s4;
	assign pwm_a     = duty_s4[0];
	assign pwm_b     = duty_s4[1];
	assign pwm_c     = duty_s4[2];
	assign fault_led = fault_s4;

`ifndef NO_ASSERTIONS
	a_phase_in_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q < PHASE_W'(CYCLE))
		else $error("phase accumulator left the table cycle");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(fault_q))
		else $error("fault latch cleared");

	a_led_follows_latch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fault_led) |-> fault_q)
		else $error("fault shown without latched fault");
`endif

endmodule

`default_nettype wire
